// File: hw/rtl/cmtp_pkg.sv
// Package for the complex matrix trace product block.
// Item type carried from the front to the back, register codes and saturation helper.
// No dependencies.
`default_nettype none

package cmtp_pkg;

    localparam int CMTP_MAX_COLORS = 16;
    localparam int CMTP_QDEPTH     = 4;

    localparam int ELEM_W  = 24;
    localparam int PROD_W  = 2 * ELEM_W;
    localparam int TERM_W  = PROD_W + 1;
    localparam int ACC_W   = 56;
    localparam int SIZE_W  = 5;
    localparam int CFG_W   = 5;
    localparam int CFG_IDX_W = 1;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MATRIX_SIZE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_TRACE_MODE  = 1'b1;

    // trace modes
    localparam logic MODE_CONJ  = 1'b0;
    localparam logic MODE_PLAIN = 1'b1;

    localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(3);

    typedef struct packed {
        logic signed [ELEM_W-1:0] a_re;
        logic signed [ELEM_W-1:0] a_im;
        logic signed [ELEM_W-1:0] b_re;
        logic signed [ELEM_W-1:0] b_im;
        logic signed [ACC_W-1:0]  start_value;
        logic                     first;
        logic                     last;
        logic                     mode;
    } t_cmtp_item;

    // Clamp a sum that is one bit wider than the accumulator.
    function automatic logic [ACC_W-1:0] sat_acc(input logic [ACC_W:0] sum);
        logic [ACC_W-1:0] res;
        if (sum[ACC_W] != sum[ACC_W-1]) begin
            res = sum[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
        end else begin
            res = sum[ACC_W-1:0];
        end
        return res;
    endfunction

    function automatic logic ovf_acc(input logic [ACC_W:0] sum);
        return sum[ACC_W] != sum[ACC_W-1];
    endfunction

endpackage

`default_nettype wire

// File: hw/rtl/cmtp_front.sv
// Front end: configuration registers, element counting and item tagging.
// Depends on cmtp_pkg.
`default_nettype none

module cmtp_front
    import cmtp_pkg::*;
#(
    parameter int MAX_COLORS = CMTP_MAX_COLORS
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [CFG_W-1:0]     i_cfg_data,
    input  wire logic                 i_in_valid,
    output logic                      o_in_ready,
    input  wire logic [ELEM_W-1:0]    i_a_re,
    input  wire logic [ELEM_W-1:0]    i_a_im,
    input  wire logic [ELEM_W-1:0]    i_b_re,
    input  wire logic [ELEM_W-1:0]    i_b_im,
    input  wire logic [ACC_W-1:0]     i_start_value,
    input  wire logic                 i_q_full,
    output logic                      o_push,
    output t_cmtp_item                o_item
);

    localparam int CNT_W = $clog2(MAX_COLORS * MAX_COLORS + 1);

    logic [SIZE_W-1:0] r_size;
    logic              r_mode;
    logic [CNT_W-1:0]  r_count;
    logic [CNT_W-1:0]  n_count;
    logic [SIZE_W-1:0] size_eff;
    logic [CNT_W-1:0]  total;
    logic [CNT_W-1:0]  count_inc;
    logic              is_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size <= SIZE_RESET;
            r_mode <= MODE_CONJ;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_MATRIX_SIZE: r_size <= i_cfg_data[SIZE_W-1:0];
                CFG_TRACE_MODE:  r_mode <= i_cfg_data[0];
            endcase
        end
    end

    always_comb begin
        if (r_size == '0) begin
            size_eff = SIZE_W'(1);
        end else if (r_size > SIZE_W'(MAX_COLORS)) begin
            size_eff = SIZE_W'(MAX_COLORS);
        end else begin
            size_eff = r_size;
        end
        total     = CNT_W'(size_eff) * CNT_W'(size_eff);
        count_inc = r_count + CNT_W'(1);
        is_last   = count_inc >= total;
        n_count   = is_last ? '0 : count_inc;
    end

    assign o_in_ready = !i_q_full;
    assign o_push     = i_in_valid && o_in_ready;

    always_comb begin
        o_item.a_re        = i_a_re;
        o_item.a_im        = i_a_im;
        o_item.b_re        = i_b_re;
        o_item.b_im        = i_b_im;
        o_item.start_value = i_start_value;
        o_item.first       = (r_count == '0);
        o_item.last        = is_last;
        o_item.mode        = r_mode;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (o_push) begin
            r_count <= n_count;
        end
    end

`ifndef SYNTHESIS
    a_count_below_total: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count < CNT_W'(MAX_COLORS * MAX_COLORS))
        else $error("element count reached the matrix bound");
    a_first_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_push && is_last) |=> (r_count == '0))
        else $error("count not cleared after last element");
    a_cfg_no_count_move: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_push |=> $stable(r_count))
        else $error("count moved without an item");
`endif

endmodule

`default_nettype wire

// File: hw/rtl/cmtp_fifo.sv
// Short item queue between front and back ends.
// Depends on cmtp_pkg.
`default_nettype none

module cmtp_fifo
    import cmtp_pkg::*;
#(
    parameter int DEPTH = CMTP_QDEPTH
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_push,
    input  wire t_cmtp_item i_item,
    output logic            o_full,
    input  wire logic       i_pop,
    output logic            o_valid,
    output t_cmtp_item      o_item
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_cmtp_item       r_mem [DEPTH];
    logic [PTR_W-1:0] r_wptr;
    logic [PTR_W-1:0] r_rptr;
    logic [CNT_W-1:0] r_count;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_item  = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= (r_wptr == PTR_W'(DEPTH - 1)) ? '0 : r_wptr + PTR_W'(1);
            end
            if (i_pop) begin
                r_rptr <= (r_rptr == PTR_W'(DEPTH - 1)) ? '0 : r_rptr + PTR_W'(1);
            end
            unique case ({i_push, i_pop})
                2'b10:   r_count <= r_count + CNT_W'(1);
                2'b01:   r_count <= r_count - CNT_W'(1);
                default: r_count <= r_count;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("queue count above depth");
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> (r_count != '0))
        else $error("pop from empty queue");
    a_push_not_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("push into full queue");
`endif

endmodule

`default_nettype wire

// File: hw/rtl/cmtp_back.sv
// Back end: four products, term combine, saturating accumulate and output register.
// Depends on cmtp_pkg.
`default_nettype none

module cmtp_back
    import cmtp_pkg::*;
(
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_q_valid,
    input  wire t_cmtp_item   i_q_item,
    output logic              o_pop,
    output logic              o_out_valid,
    input  wire logic         i_out_ready,
    output logic [ACC_W-1:0]  o_trace_re,
    output logic [ACC_W-1:0]  o_trace_im,
    output logic              o_saturated
);

    typedef struct packed {
        logic                     first;
        logic                     last;
        logic                     mode;
        logic [ACC_W-1:0]         start_value;
        logic signed [PROD_W-1:0] p_rr;
        logic signed [PROD_W-1:0] p_ii;
        logic signed [PROD_W-1:0] p_ri;
        logic signed [PROD_W-1:0] p_ir;
    } t_prod_stage;

    typedef struct packed {
        logic              first;
        logic              last;
        logic              mode;
        logic [ACC_W-1:0]  start_value;
        logic [TERM_W-1:0] term_re;
        logic [TERM_W-1:0] term_im;
    } t_term_stage;

    logic        advance;
    logic        r_s1_valid;
    t_prod_stage r_s1;
    logic        r_s2_valid;
    t_term_stage r_s2;

    logic [ACC_W-1:0] r_acc_re;
    logic [ACC_W-1:0] r_acc_im;
    logic             r_ovf;
    logic [ACC_W-1:0] n_acc_re;
    logic [ACC_W-1:0] n_acc_im;
    logic             n_ovf;

    logic             r_out_valid;
    logic [ACC_W-1:0] r_trace_re;
    logic [ACC_W-1:0] r_trace_im;
    logic             r_sat;

    logic [TERM_W-1:0] rr_x, ii_x, ri_x, ir_x;
    logic [ACC_W-1:0]  base_re, base_im;
    logic              base_ovf;
    logic [ACC_W:0]    sum_re, sum_im;

    // whole pipeline holds while a finished result waits
    assign advance = !r_out_valid || i_out_ready;
    assign o_pop   = advance && i_q_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else if (advance) begin
            r_s1_valid <= i_q_valid;
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_s1.first       <= i_q_item.first;
            r_s1.last        <= i_q_item.last;
            r_s1.mode        <= i_q_item.mode;
            r_s1.start_value <= i_q_item.start_value;
            r_s1.p_rr        <= i_q_item.a_re * i_q_item.b_re;
            r_s1.p_ii        <= i_q_item.a_im * i_q_item.b_im;
            r_s1.p_ri        <= i_q_item.a_re * i_q_item.b_im;
            r_s1.p_ir        <= i_q_item.a_im * i_q_item.b_re;
        end
    end

    always_comb begin
        rr_x = {r_s1.p_rr[PROD_W-1], r_s1.p_rr};
        ii_x = {r_s1.p_ii[PROD_W-1], r_s1.p_ii};
        ri_x = {r_s1.p_ri[PROD_W-1], r_s1.p_ri};
        ir_x = {r_s1.p_ir[PROD_W-1], r_s1.p_ir};
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_s2.first       <= r_s1.first;
            r_s2.last        <= r_s1.last;
            r_s2.mode        <= r_s1.mode;
            r_s2.start_value <= r_s1.start_value;
            if (r_s1.mode == MODE_PLAIN) begin
                r_s2.term_re <= rr_x - ii_x;
                r_s2.term_im <= '0;
            end else begin
                r_s2.term_re <= rr_x + ii_x;
                r_s2.term_im <= ri_x - ir_x;
            end
        end
    end

    always_comb begin
        base_re  = r_s2.first ? r_s2.start_value : r_acc_re;
        base_im  = r_s2.first ? '0 : r_acc_im;
        base_ovf = r_s2.first ? 1'b0 : r_ovf;
        sum_re   = {base_re[ACC_W-1], base_re}
                 + {{(ACC_W + 1 - TERM_W){r_s2.term_re[TERM_W-1]}}, r_s2.term_re};
        sum_im   = {base_im[ACC_W-1], base_im}
                 + {{(ACC_W + 1 - TERM_W){r_s2.term_im[TERM_W-1]}}, r_s2.term_im};
        n_acc_re = sat_acc(sum_re);
        n_acc_im = sat_acc(sum_im);
        n_ovf    = base_ovf || ovf_acc(sum_re) || ovf_acc(sum_im);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc_re <= '0;
            r_acc_im <= '0;
            r_ovf    <= 1'b0;
        end else if (advance && r_s2_valid) begin
            r_acc_re <= n_acc_re;
            r_acc_im <= n_acc_im;
            r_ovf    <= n_ovf;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_s2_valid && r_s2.last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && r_s2_valid && r_s2.last) begin
            r_trace_re <= n_acc_re;
            r_trace_im <= n_acc_im;
            r_sat      <= n_ovf;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_trace_re  = r_trace_re;
    assign o_trace_im  = r_trace_im;
    assign o_saturated = r_sat;

`ifndef SYNTHESIS
    a_last_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && r_s2_valid && r_s2.last) |=> r_out_valid)
        else $error("last element produced no result");
    a_plain_keeps_imag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && r_s2_valid && !r_s2.first && r_s2.mode == MODE_PLAIN)
        |=> $stable(r_acc_im))
        else $error("plain mode changed imaginary sum");
    a_stall_keeps_stage: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!advance && r_s1_valid) |=> r_s1_valid)
        else $error("stalled item lost from product stage");
`endif

endmodule

`default_nettype wire

// File: hw/rtl/complex_matrix_trace_product.sv
// A result is valid once a matrix's last item has passed the queue write and then the
// product, term and accumulate-to-output stages; a stall can hold it in between.
// Throughput: one item per cycle unless stalled; the 56-bit saturating accumulate loop sets it.
// A waiting result stalls the back end; the front takes items until the 4-entry queue is full.
// Reset (synchronous, active low) clears counts, sums, flags and queue; size 3, conjugate mode.
// Top level: front end, item queue and back end. Depends on cmtp_pkg.
`default_nettype none

module complex_matrix_trace_product
    import cmtp_pkg::*;
#(
    parameter int MAX_COLORS = CMTP_MAX_COLORS
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [CFG_W-1:0]     i_cfg_data,
    input  wire logic                 i_in_valid,
    output logic                      o_in_ready,
    input  wire logic [ELEM_W-1:0]    i_a_re,
    input  wire logic [ELEM_W-1:0]    i_a_im,
    input  wire logic [ELEM_W-1:0]    i_b_re,
    input  wire logic [ELEM_W-1:0]    i_b_im,
    input  wire logic [ACC_W-1:0]     i_start_value,
    output logic                      o_out_valid,
    input  wire logic                 i_out_ready,
    output logic [ACC_W-1:0]          o_trace_re,
    output logic [ACC_W-1:0]          o_trace_im,
    output logic                      o_saturated
);

    logic       q_full;
    logic       push;
    t_cmtp_item push_item;
    logic       q_valid;
    logic       pop;
    t_cmtp_item head_item;

    cmtp_front #(
        .MAX_COLORS (MAX_COLORS)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_a_re        (i_a_re),
        .i_a_im        (i_a_im),
        .i_b_re        (i_b_re),
        .i_b_im        (i_b_im),
        .i_start_value (i_start_value),
        .i_q_full      (q_full),
        .o_push        (push),
        .o_item        (push_item)
    );

    cmtp_fifo #(
        .DEPTH (CMTP_QDEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (push_item),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_item  (head_item)
    );

    cmtp_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_q_item    (head_item),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_trace_re  (o_trace_re),
        .o_trace_im  (o_trace_im),
        .o_saturated (o_saturated)
    );

endmodule

`default_nettype wire
